// File: rtl/ttb_pkg.sv
`timescale 1ns / 1ps
package ttb_pkg;

    localparam int ONE_Q14   = 16384;
    localparam int UV_W      = 16;
    localparam int NRM_W     = 16;
    localparam int A_W       = 30;
    localparam int SQ_W      = 62;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 33;
    localparam int NUM_W     = 45;
    localparam int Q_W       = 15;

    typedef struct packed {
        logic [47:0] v0_normal;
        logic [31:0] v2_uv;
        logic [31:0] v1_uv;
        logic [31:0] v0_uv;
        logic [47:0] v2_position;
        logic [47:0] v1_position;
        logic [47:0] v0_position;
    } t_in;

    typedef struct packed {
        logic               degenerate;
        logic signed [15:0] binormal_z;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_x;
        logic signed [15:0] tangent_z;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_x;
    } t_out;

    // side data carried through the square root stages
    typedef struct packed {
        logic [2:0][A_W-1:0] a;
        logic [2:0]          neg;
        logic                deg;
        logic [47:0]         normal;
    } t_sr_carry;

    // side data carried through the divider stages
    typedef struct packed {
        logic [2:0][NUM_W-1:0] r;
        logic [2:0][Q_W-1:0]   q;
        logic [ROOT_W-1:0]     len;
        logic [2:0]            neg;
        logic                  deg;
        logic [47:0]           normal;
    } t_dv_carry;

endpackage

// File: rtl/triangle_tangent_basis_unit.sv
`timescale 1ns / 1ps
// triangle tangent basis unit
// input channel: i_valid / o_stall with i_data, one triangle per transfer
// (three Q8.8 positions, three Q4.12 texture coordinates, first normal Q1.14)
// output channel: o_valid / i_stall with o_data, one result per triangle
// (unit tangent, normal cross tangent, degenerate flag)
// a transfer happens on a clock edge where valid is high and stall is low
// throughput is one triangle per cycle unless i_stall holds the result;
// the depth is set by the 31-step square root pipeline and the 15-step
// quotient pipeline of the normalizer
// degenerate triangles (zero uv determinant or zero tangent) give all-zero
// vectors with degenerate set
// reset (i_rst_n low, synchronous) empties every stage; data in flight is
// dropped and o_valid goes low
// while the result is held by i_stall the whole pipeline freezes and o_stall
// is raised; nothing is lost or repeated
module triangle_tangent_basis_unit
    import ttb_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int DW   = UV_W + 1;
    localparam int PW1  = CW + 18;
    localparam int TW   = CW + 19;
    localparam int AW   = CW + 18;
    localparam int DETW = 2 * DW + 1;
    localparam int BLW  = $clog2(AW + 1);
    localparam int PADW = 3 * CW + 48;

    logic en;
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;
    assign o_valid = r_out_valid;

    // stage a: edges and uv deltas
    logic                        r_a_v;
    logic signed [2:0][EW-1:0]   r_e1, r_e2;
    logic signed [DW-1:0]        r_d1u, r_d1v, r_d2u, r_d2v;
    logic [47:0]                 r_a_n;
    logic [PADW-1:0]             p0x, p1x, p2x;
    logic signed [2:0][EW-1:0]   n_e1, n_e2;

    assign p0x = {{(3 * CW){1'b0}}, i_data.v0_position};
    assign p1x = {{(3 * CW){1'b0}}, i_data.v1_position};
    assign p2x = {{(3 * CW){1'b0}}, i_data.v2_position};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e1[i] = EW'($signed(p1x[i*CW +: CW])) - EW'($signed(p0x[i*CW +: CW]));
            n_e2[i] = EW'($signed(p2x[i*CW +: CW])) - EW'($signed(p0x[i*CW +: CW]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1  <= n_e1;
            r_e2  <= n_e2;
            r_d1u <= DW'($signed(i_data.v1_uv[15:0]))  - DW'($signed(i_data.v0_uv[15:0]));
            r_d1v <= DW'($signed(i_data.v1_uv[31:16])) - DW'($signed(i_data.v0_uv[31:16]));
            r_d2u <= DW'($signed(i_data.v2_uv[15:0]))  - DW'($signed(i_data.v0_uv[15:0]));
            r_d2v <= DW'($signed(i_data.v2_uv[31:16])) - DW'($signed(i_data.v0_uv[31:16]));
            r_a_n <= i_data.v0_normal;
        end
    end

    // stage b: products
    logic                       r_b_v;
    logic signed [2:0][PW1-1:0] r_p1, r_p2;
    logic signed [2*DW-1:0]     r_pd1, r_pd2;
    logic [47:0]                r_b_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= PW1'($signed(r_e1[i])) * PW1'(r_d2v);
                r_p2[i] <= PW1'($signed(r_e2[i])) * PW1'(r_d1v);
            end
            r_pd1 <= (2*DW)'(r_d1u) * (2*DW)'(r_d2v);
            r_pd2 <= (2*DW)'(r_d2u) * (2*DW)'(r_d1v);
            r_b_n <= r_a_n;
        end
    end

    // stage c: raw tangent and determinant
    logic                      r_c_v;
    logic signed [2:0][TW-1:0] r_t;
    logic signed [DETW-1:0]    r_det;
    logic [47:0]               r_c_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= TW'($signed(r_p1[i])) - TW'($signed(r_p2[i]));
            end
            r_det <= DETW'(r_pd1) - DETW'(r_pd2);
            r_c_n <= r_b_n;
        end
    end

    // stage d: sign fix, magnitudes, degenerate check
    logic                 r_d_v;
    logic [2:0][AW-1:0]   r_mag;
    logic [2:0]           r_d_neg;
    logic                 r_d_deg;
    logic [47:0]          r_d_n;
    logic signed [TW-1:0] tt [3];
    logic signed [TW-1:0] ta [3];
    logic [2:0][AW-1:0]   n_mag;
    logic [2:0]           n_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tt[i]    = r_det[DETW-1] ? -$signed(r_t[i]) : $signed(r_t[i]);
            n_neg[i] = tt[i][TW-1];
            ta[i]    = n_neg[i] ? -tt[i] : tt[i];
            n_mag[i] = ta[i][AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag   <= n_mag;
            r_d_neg <= n_neg;
            r_d_deg <= (r_det == '0) || (r_t == '0);
            r_d_n   <= r_c_n;
        end
    end

    // stage e: range reduction to 30 bits
    logic              r_e_v;
    t_sr_carry         r_e_c;
    logic [AW-1:0]     mx;
    logic [BLW-1:0]    blen, sh;
    logic [AW+29:0]    shx [3];
    logic [2:0][A_W-1:0] n_ared;

    always_comb begin
        mx = r_mag[0];
        if (r_mag[1] > mx) mx = r_mag[1];
        if (r_mag[2] > mx) mx = r_mag[2];
        blen = '0;
        for (int k = 0; k < AW; k++) begin
            if (mx[k]) blen = BLW'(k + 1);
        end
        sh = (blen > BLW'(A_W)) ? blen - BLW'(A_W) : '0;
        for (int i = 0; i < 3; i++) begin
            shx[i]    = {{A_W{1'b0}}, r_mag[i]} >> sh;
            n_ared[i] = shx[i][A_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_c.a      <= n_ared;
            r_e_c.neg    <= r_d_neg;
            r_e_c.deg    <= r_d_deg;
            r_e_c.normal <= r_d_n;
        end
    end

    // stage f: squares
    logic                      r_f_v;
    logic [2:0][2*A_W-1:0]     r_sq;
    t_sr_carry                 r_f_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*A_W)'(r_e_c.a[i]) * (2*A_W)'(r_e_c.a[i]);
            end
            r_f_c <= r_e_c;
        end
    end

    // square root pipeline, one result bit per stage; index 0 holds the sum
    logic              r_sr_v    [0:ROOT_W];
    logic [REM_W-1:0]  r_sr_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_sr_root [0:ROOT_W];
    logic [SQ_W-1:0]   r_sr_sum  [0:ROOT_W-1];
    t_sr_carry         r_sr_c    [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr_v[0] <= 1'b0;
        end else if (en) begin
            r_sr_v[0] <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr_sum[0]  <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
            r_sr_c[0]    <= r_f_c;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int P = ROOT_W - 1 - j;
        logic [REM_W+1:0] cur, trial;
        logic             ge;

        assign cur   = {r_sr_rem[j], r_sr_sum[j][2*P+1 -: 2]};
        assign trial = {2'b00, r_sr_root[j], 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_v[j+1] <= 1'b0;
            end else if (en) begin
                r_sr_v[j+1] <= r_sr_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sr_rem[j+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                r_sr_root[j+1] <= {r_sr_root[j][ROOT_W-2:0], ge};
                r_sr_c[j+1]    <= r_sr_c[j];
            end
        end

        if (j < ROOT_W - 1) begin : g_sum
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sr_sum[j+1] <= r_sr_sum[j];
                end
            end
        end
    end

    // quotient pipeline, one bit per stage; index 0 holds the rounded numerators
    logic      r_dv_v [0:Q_W];
    t_dv_carry r_dv   [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sr_v[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv[0].r[i] <= (NUM_W'(r_sr_c[ROOT_W].a[i]) << 14)
                              + NUM_W'(r_sr_root[ROOT_W] >> 1);
            end
            r_dv[0].q      <= '0;
            r_dv[0].len    <= r_sr_root[ROOT_W];
            r_dv[0].neg    <= r_sr_c[ROOT_W].neg;
            r_dv[0].deg    <= r_sr_c[ROOT_W].deg;
            r_dv[0].normal <= r_sr_c[ROOT_W].normal;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        localparam int B = Q_W - 1 - k;
        logic [NUM_W-1:0] dsh;
        t_dv_carry        nx;

        assign dsh = NUM_W'(r_dv[k].len) << B;

        always_comb begin
            nx = r_dv[k];
            for (int i = 0; i < 3; i++) begin
                if (r_dv[k].r[i] >= dsh) begin
                    nx.r[i] = r_dv[k].r[i] - dsh;
                    nx.q[i] = {r_dv[k].q[i][Q_W-2:0], 1'b1};
                end else begin
                    nx.q[i] = {r_dv[k].q[i][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k+1] <= nx;
            end
        end
    end

    // stage i: signed tangent and cross products
    logic                     r_i_v;
    logic signed [2:0][15:0]  r_tn;
    logic signed [5:0][31:0]  r_cp;
    logic                     r_i_deg;
    logic signed [15:0]       tn [3];
    logic signed [15:0]       nv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tn[i] = r_dv[Q_W].neg[i] ? -(16'(r_dv[Q_W].q[i])) : 16'(r_dv[Q_W].q[i]);
            nv[i] = $signed(r_dv[Q_W].normal[i*NRM_W +: NRM_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (en) begin
            r_i_v <= r_dv_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_tn[i] <= tn[i];
            end
            r_cp[0] <= 32'(nv[1]) * 32'(tn[2]);
            r_cp[1] <= 32'(nv[2]) * 32'(tn[1]);
            r_cp[2] <= 32'(nv[2]) * 32'(tn[0]);
            r_cp[3] <= 32'(nv[0]) * 32'(tn[2]);
            r_cp[4] <= 32'(nv[0]) * 32'(tn[1]);
            r_cp[5] <= 32'(nv[1]) * 32'(tn[0]);
            r_i_deg <= r_dv[Q_W].deg;
        end
    end

    // stage j: binormal rounding, saturation, output register
    logic signed [31:0] bx [3];
    logic signed [31:0] br [3];
    logic signed [15:0] bs [3];
    t_out               r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bx[i] = $signed(r_cp[2*i]) - $signed(r_cp[2*i+1]);
            br[i] = (bx[i] + 32'sd8192) >>> 14;
            if (br[i] > 32'sd16384) begin
                bs[i] = 16'(ONE_Q14);
            end else if (br[i] < -32'sd16384) begin
                bs[i] = -16'(ONE_Q14);
            end else begin
                bs[i] = br[i][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.degenerate <= r_i_deg;
            r_out.tangent_x  <= r_i_deg ? '0 : r_tn[0];
            r_out.tangent_y  <= r_i_deg ? '0 : r_tn[1];
            r_out.tangent_z  <= r_i_deg ? '0 : r_tn[2];
            r_out.binormal_x <= r_i_deg ? '0 : bs[0];
            r_out.binormal_y <= r_i_deg ? '0 : bs[1];
            r_out.binormal_z <= r_i_deg ? '0 : bs[2];
        end
    end

    assign o_data = r_out;

endmodule
